/* rtl/scc_pkg.sv */
// shared constants, types and the crc-8 byte update for the scratchpad check
package scc_pkg;

	localparam int unsigned DataW  = 8;
	localparam int unsigned PosW   = 4;
	localparam int unsigned RawW   = 16;
	localparam int unsigned TempW  = 16;

	localparam logic [DataW-1:0] CrcPoly    = 8'h8C;
	localparam logic [PosW-1:0]  PosIdle    = 4'd0;
	localparam logic [PosW-1:0]  PosCheck   = 4'd8;
	localparam logic [PosW-1:0]  FrameBytes = 4'd9;

	// what the frame tracker reports for the request under way
	typedef struct packed {
		logic            done;
		logic            ok;
		logic [RawW-1:0] raw;
	} frame_res_t;

	// reflected crc-8, one bit per step, lsb first
	function automatic logic [DataW-1:0] crc8_byte(
		input logic [DataW-1:0] crc,
		input logic [DataW-1:0] b
	);
		logic [DataW-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/scc_in_if.sv */
// byte channel into the scratchpad check
interface scc_in_if;
	logic                        valid;
	logic                        ready;
	logic [scc_pkg::DataW-1:0]   data_byte;
	logic                        frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* rtl/scc_out_if.sv */
// result channel out of the scratchpad check
interface scc_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [scc_pkg::TempW-1:0] temperature_tenths;
	logic                        crc_ok;

	modport source (output valid, output temperature_tenths, output crc_ok, input ready);
	modport sink   (input valid, input temperature_tenths, input crc_ok, output ready);
endinterface

/* rtl/scc_frame.sv */
// frame tracker: byte position, running crc and the two raw temperature bytes
module scc_frame (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [scc_pkg::DataW-1:0]  data_byte,
	input  logic                       frame_start,
	output scc_pkg::frame_res_t        res
);

	logic [scc_pkg::PosW-1:0]  pos_q;
	logic [scc_pkg::DataW-1:0] crc_q;
	logic [scc_pkg::DataW-1:0] raw_lo_q;
	logic [scc_pkg::DataW-1:0] raw_hi_q;

	logic [scc_pkg::PosW-1:0]  pos;
	logic [scc_pkg::DataW-1:0] crc_base;
	logic                      ignore;
	logic                      check;

	always_comb begin
		pos      = frame_start ? scc_pkg::PosIdle : pos_q;
		crc_base = frame_start ? '0 : crc_q;
		// no open frame, byte dropped
		ignore   = !frame_start && ((pos_q == scc_pkg::PosIdle) || (pos_q >= scc_pkg::FrameBytes));
		check    = !ignore && (pos == scc_pkg::PosCheck);
		res.done = check;
		res.ok   = (data_byte == crc_q);
		res.raw  = {raw_hi_q, raw_lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= '0;
			raw_lo_q <= '0;
			raw_hi_q <= '0;
		end else if (en && !ignore) begin
			if (check) begin
				pos_q <= scc_pkg::PosIdle;
			end else begin
				crc_q <= scc_pkg::crc8_byte(crc_base, data_byte);
				pos_q <= pos + 4'd1;
				if (pos == 4'd0) begin
					raw_lo_q <= data_byte;
				end else if (pos == 4'd1) begin
					raw_hi_q <= data_byte;
				end
			end
		end
	end

endmodule

/* rtl/scc_temp.sv */
// raw sensor value to tenths of a degree, times 10 over 16 toward zero
module scc_temp (
	input  logic [scc_pkg::RawW-1:0]         raw,
	input  logic                             ok,
	output logic signed [scc_pkg::TempW-1:0] tenths
);

	logic signed [19:0] ext;
	logic signed [19:0] prod;
	logic signed [19:0] biased;

	always_comb begin
		ext    = {{4{raw[15]}}, raw};
		prod   = (ext <<< 3) + (ext <<< 1);
		// bias negatives so the shift truncates toward zero
		biased = prod + (prod[19] ? 20'sd15 : 20'sd0);
		tenths = ok ? biased[19:4] : '0;
	end

endmodule

/* rtl/scratchpad_crc_temperature_check.sv */
// scratchpad crc check: the ninth byte's result passes the input register and then
// the result register; one byte accepted every cycle
// while the result register is free or being drained
// only the ninth byte of a frame makes a result; other bytes of the frame update crc state
// arst_n clears position, crc, raw bytes and both valid flags
module scratchpad_crc_temperature_check (
	input  logic clk,
	input  logic arst_n,
	scc_in_if.sink    sample,
	scc_out_if.source result
);

	logic                       vld_s1;
	logic [scc_pkg::DataW-1:0]  data_s1;
	logic                       start_s1;

	logic                              out_vld_q;
	logic signed [scc_pkg::TempW-1:0]  temp_q;
	logic                              ok_q;

	scc_pkg::frame_res_t               fres;
	logic signed [scc_pkg::TempW-1:0]  tenths;
	logic                              out_free;
	logic                              take_s1;

	scc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (take_s1),
		.data_byte   (data_s1),
		.frame_start (start_s1),
		.res         (fres)
	);

	scc_temp u_temp (
		.raw    (fres.raw),
		.ok     (fres.ok),
		.tenths (tenths)
	);

	always_comb begin
		out_free     = !out_vld_q || result.ready;
		// a byte without a result moves on even while the result waits
		take_s1      = vld_s1 && (!fres.done || out_free);
		sample.ready = !vld_s1 || take_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample.ready) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			data_s1  <= sample.data_byte;
			start_s1 <= sample.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take_s1 && fres.done) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && fres.done) begin
			temp_q <= tenths;
			ok_q   <= fres.ok;
		end
	end

	assign result.valid              = out_vld_q;
	assign result.temperature_tenths = temp_q;
	assign result.crc_ok             = ok_q;

endmodule
